FILE: hdl/sks_pkg.sv
package sks_pkg;

    // Field widths
    localparam int KEY_W    = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int KCOUNT_W = 7;

    // Request operation codes (code 3 behaves as a member query)
    localparam logic [CMD_W-1:0] CMD_MEMBER = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOCHANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic signed [KEY_W-1:0] key;
    } t_request;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KCOUNT_W-1:0] key_count;
    } t_result;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    // What the scan does with each entry it reads
    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_INSERT,
        PH_REMOVE
    } t_phase;

endpackage

FILE: hdl/sks_store.sv
module sks_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [AW-1:0]                  i_waddr,
    input  logic signed [sks_pkg::KEY_W-1:0] i_wdata,
    input  logic [AW-1:0]                  i_raddr,
    output logic signed [sks_pkg::KEY_W-1:0] o_rdata
);
    import sks_pkg::*;

    logic signed [KEY_W-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

FILE: hdl/sks_ctrl.sv
module sks_ctrl #(
    parameter int CAPACITY = 64,
    parameter int AW       = 6,
    parameter int CW       = 7
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  sks_pkg::t_request                i_req,
    output logic                             o_busy,
    output logic                             o_done,
    output sks_pkg::t_result                 o_res,
    output logic                             o_we,
    output logic [AW-1:0]                    o_waddr,
    output logic signed [sks_pkg::KEY_W-1:0] o_wdata,
    output logic [AW-1:0]                    o_raddr,
    input  logic signed [sks_pkg::KEY_W-1:0] i_rdata
);
    import sks_pkg::*;

    t_state                  r_state, n_state;
    t_phase                  r_phase, n_phase;
    logic [CW-1:0]           r_idx, n_idx;
    logic [CW-1:0]           r_count, n_count;
    logic [CMD_W-1:0]        r_cmd, n_cmd;
    logic signed [KEY_W-1:0] r_key, n_key;
    logic signed [KEY_W-1:0] r_carry, n_carry;
    logic                    r_done, n_done;
    t_result                 r_res, n_res;

    logic                    fin;
    logic                    in_range;
    logic                    full;
    logic [CW-1:0]           idx_inc;
    logic [CW-1:0]           idx_dec;

    assign in_range = (r_idx < r_count);
    assign full     = (r_count >= CW'(CAPACITY));
    assign idx_inc  = r_idx + CW'(1);
    assign idx_dec  = r_idx - CW'(1);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (fin) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Scan datapath: entry r_idx arrives from the store this cycle,
    // entry r_idx+1 is read ahead.
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_count = r_count;
        n_cmd   = r_cmd;
        n_key   = r_key;
        n_carry = r_carry;
        n_done  = 1'b0;
        n_res   = r_res;
        fin     = 1'b0;
        o_we    = 1'b0;
        o_waddr = r_idx[AW-1:0];
        o_wdata = r_carry;
        o_raddr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd   = i_req.cmd;
                    n_key   = i_req.key;
                    n_idx   = '0;
                    n_phase = PH_SEARCH;
                end
            end
            S_SCAN: begin
                o_raddr = idx_inc[AW-1:0];
                n_idx   = idx_inc;
                unique case (r_phase)
                    PH_SEARCH: begin
                        if (!in_range || i_rdata > r_key) begin
                            // key absent; r_idx is its ordered position
                            if (r_cmd == CMD_INSERT) begin
                                if (full) begin
                                    fin          = 1'b1;
                                    n_res.status = ST_FULL;
                                end else if (!in_range) begin
                                    o_we         = 1'b1;
                                    o_wdata      = r_key;
                                    n_count      = r_count + CW'(1);
                                    fin          = 1'b1;
                                    n_res.status = ST_OK;
                                end else begin
                                    o_we    = 1'b1;
                                    o_wdata = r_key;
                                    n_carry = i_rdata;
                                    n_phase = PH_INSERT;
                                end
                            end else begin
                                fin          = 1'b1;
                                n_res.status = ST_NOCHANGE;
                            end
                        end else if (i_rdata == r_key) begin
                            if (r_cmd == CMD_INSERT) begin
                                fin          = 1'b1;
                                n_res.status = ST_NOCHANGE;
                            end else if (r_cmd == CMD_REMOVE) begin
                                n_phase = PH_REMOVE;
                            end else begin
                                fin          = 1'b1;
                                n_res.status = ST_OK;
                            end
                        end
                    end
                    PH_INSERT: begin
                        // ripple the displaced entry one place up
                        o_we = 1'b1;
                        if (in_range) begin
                            n_carry = i_rdata;
                        end else begin
                            n_count      = r_count + CW'(1);
                            fin          = 1'b1;
                            n_res.status = ST_OK;
                        end
                    end
                    PH_REMOVE: begin
                        // pull each later entry one place down
                        if (in_range) begin
                            o_we    = 1'b1;
                            o_waddr = idx_dec[AW-1:0];
                            o_wdata = i_rdata;
                        end else begin
                            n_count      = r_count - CW'(1);
                            fin          = 1'b1;
                            n_res.status = ST_OK;
                        end
                    end
                    default: begin
                        fin          = 1'b1;
                        n_res.status = ST_NOCHANGE;
                    end
                endcase
                if (fin) begin
                    n_done          = 1'b1;
                    n_res.key_count = KCOUNT_W'(n_count);
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;
        r_idx   <= n_idx;
        r_cmd   <= n_cmd;
        r_key   <= n_key;
        r_carry <= n_carry;
        r_res   <= n_res;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

FILE: hdl/sorted_key_set_engine_top.sv
// Ordered set of up to CAPACITY distinct signed 32-bit keys held in one
// single-port-write, registered-read RAM. A request (cmd, key) is taken when
// start is high and busy is low; busy then stays high until the result shows.
// Each request does one forward pass over the stored keys, one entry per
// clock: the search stops at the first key not below the request key, an
// insert then ripples later entries up one place, a remove pulls them down
// one place; busy covers the whole pass, which is paced by the RAM's single
// read per cycle. The result appears on o_res for exactly one cycle with
// o_done high and must be captured then; there is no back-pressure. busy is
// already low in that cycle, so a new request may be issued alongside it.
// Status 0 means found, inserted or removed; 1 means absent or duplicate;
// 2 means the table is full and the insert was refused. key_count is the
// count after the request, reported in 7 bits.
module sorted_key_set_engine_top #(
    parameter int CAPACITY = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  sks_pkg::t_request i_req,
    output logic              busy,
    output logic              o_done,
    output sks_pkg::t_result  o_res
);
    import sks_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic signed [KEY_W-1:0] mem_wdata;
    logic [AW-1:0]           mem_raddr;
    logic signed [KEY_W-1:0] mem_rdata;

    // Sequencer
    sks_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (i_req),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_res   (o_res),
        .o_we    (mem_we),
        .o_waddr (mem_waddr),
        .o_wdata (mem_wdata),
        .o_raddr (mem_raddr),
        .i_rdata (mem_rdata)
    );

    // Key storage
    sks_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

FILE: hdl/sks_checker.sv
module sks_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input sks_pkg::t_result  o_res
);
    import sks_pkg::*;

    // A taken request keeps the engine busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request taken but engine not busy");

    // Results never come back to back
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("two results in consecutive cycles");

    // The engine drops busy exactly when its result shows
    a_busy_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy fell without a result");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while still busy");

    // Status is one of the three defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_res.status == ST_OK || o_res.status == ST_NOCHANGE ||
                    o_res.status == ST_FULL))
        else $error("undefined status code");

endmodule

bind sorted_key_set_engine_top sks_checker u_sks_checker (.*);

FILE: tb/sorted_key_set_engine_top_tb.sv
module sorted_key_set_engine_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sks_pkg::*;

    localparam int CAPACITY       = 64;
    localparam int CLK_PERIOD     = 20;
    localparam int TAIL_CYCLES    = CAPACITY + 4;
    localparam int CYCLE_LIMIT    = 900_000;
    localparam int MAX_REPORTS    = 10;
    // Unused operation code, behaves as a member query
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    t_request i_req;
    logic     busy;
    logic     o_done;
    t_result  o_res;

    // Shadow copy of the ordered key table
    logic signed [KEY_W-1:0] held_keys [CAPACITY];
    int held_count;
    int peak_count;

    t_result expected_results[$];
    int      mismatch_count;
    int      cycle_count;
    int      result_count;
    int      insert_count;
    int      remove_count;
    int      query_count;
    int      full_refusals;
    bit      sender_idles;

    sorted_key_set_engine_top #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Apply one request to the shadow table and return the answer it gives
    function automatic t_result apply_to_key_table(t_request req);
        int      pos;
        bit      hit;
        t_result res;
        pos = 0;
        while (pos < held_count && held_keys[pos] < req.key)
            pos++;
        hit = (pos < held_count) && (held_keys[pos] == req.key);
        case (req.cmd)
            CMD_INSERT: begin
                insert_count++;
                if (hit) begin
                    res.status = ST_NOCHANGE;
                end else if (held_count >= CAPACITY) begin
                    res.status = ST_FULL;
                    full_refusals++;
                end else begin
                    for (int j = held_count; j > pos; j--)
                        held_keys[j] = held_keys[j-1];
                    held_keys[pos] = req.key;
                    held_count++;
                    res.status = ST_OK;
                end
            end
            CMD_REMOVE: begin
                remove_count++;
                if (hit) begin
                    for (int j = pos; j + 1 < held_count; j++)
                        held_keys[j] = held_keys[j+1];
                    held_count--;
                    res.status = ST_OK;
                end else begin
                    res.status = ST_NOCHANGE;
                end
            end
            default: begin
                query_count++;
                res.status = hit ? ST_OK : ST_NOCHANGE;
            end
        endcase
        if (held_count > peak_count)
            peak_count = held_count;
        res.key_count = held_count[KCOUNT_W-1:0];
        return res;
    endfunction

    // Result checker: o_done marks a one-cycle result that must be taken now
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            result_count++;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("[%0t] unexpected result: status %0d count %0d",
                             $realtime, o_res.status, o_res.key_count);
            end else begin
                want = expected_results.pop_front();
                if (o_res.status !== want.status || o_res.key_count !== want.key_count) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("[%0t] result %0d: status exp %0d got %0d, count exp %0d got %0d",
                                 $realtime, result_count, want.status, o_res.status,
                                 want.key_count, o_res.key_count);
                end
            end
        end
    end

    // Issue one request, holding start until the engine takes it
    task automatic send_request(input logic [CMD_W-1:0] cmd,
                                input logic signed [KEY_W-1:0] key);
        t_request req;
        int       gap;
        req.cmd = cmd;
        req.key = key;
        gap = sender_idles ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy);
        expected_results.push_back(apply_to_key_table(req));
    endtask

    // Drop start and hold off until every outstanding result is back
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    // Extremes, every operation and the corner cases on a small table
    task automatic test_directed_ops();
        sender_idles = 1'b0;
        send_request(CMD_MEMBER, KEY_MIN);        // query on empty table
        send_request(CMD_REMOVE, 32'sd5);         // remove on empty table
        send_request(CMD_INSERT, 32'sd0);
        send_request(CMD_INSERT, KEY_MAX);
        send_request(CMD_INSERT, KEY_MIN);
        send_request(CMD_INSERT, -32'sd1);
        send_request(CMD_INSERT, 32'sd1);
        send_request(CMD_INSERT, 32'sd0);         // duplicate
        send_request(CMD_INSERT, 32'sh5555_5555);
        send_request(CMD_INSERT, 32'shAAAA_AAAA);
        send_request(CMD_MEMBER, KEY_MAX);
        send_request(CMD_MEMBER, 32'sd2);
        send_request(CMD_UNUSED, KEY_MIN);        // unused code, hit
        send_request(CMD_UNUSED, 32'sd7);         // unused code, miss
        sender_idles = 1'b1;
        send_request(CMD_REMOVE, 32'sd1);
        send_request(CMD_REMOVE, 32'sd1);         // already gone
        send_request(CMD_REMOVE, KEY_MIN);
        send_request(CMD_REMOVE, KEY_MAX);
        send_request(CMD_MEMBER, 32'sd0);
        send_request(CMD_REMOVE, 32'shAAAA_AAAA);
    endtask

    // Fill the table, then hit it with refused, duplicate and boundary requests
    task automatic test_fill_to_capacity();
        int step;
        step = 0;
        sender_idles = 1'b1;
        while (held_count < CAPACITY && step < 4 * CAPACITY) begin
            send_request(CMD_INSERT, ((step * 37) % 101) * 1000 - 50000);
            step++;
        end
        send_request(CMD_INSERT, KEY_MAX);        // refused, table full
        send_request(CMD_INSERT, KEY_MIN);        // refused, table full
        send_request(CMD_INSERT, held_keys[0]);   // duplicate while full
        send_request(CMD_MEMBER, held_keys[CAPACITY-1]);
        send_request(CMD_UNUSED, held_keys[CAPACITY/2]);
        send_request(CMD_REMOVE, held_keys[CAPACITY-1]);
        send_request(CMD_INSERT, KEY_MAX);        // room again, lands last
        send_request(CMD_INSERT, 32'sd123457);    // refused again
    endtask

    // Random traffic over a small key pool so hits and a full table are common
    task automatic test_random_mix(input int n_items, input int insert_pct,
                                   input int remove_pct);
        logic signed [KEY_W-1:0] key_pool [80];
        logic [CMD_W-1:0]        cmd;
        logic signed [KEY_W-1:0] key;
        int                      roll;
        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = 32'sd0;
        key_pool[3] = -32'sd1;
        for (int p = 4; p < 80; p++)
            key_pool[p] = (p % 2) ? $urandom() : $urandom_range(0, 400) - 200;
        for (int n = 0; n < n_items; n++) begin
            if (n % 40 == 0)
                sender_idles = ($urandom_range(0, 3) != 0);
            roll = $urandom_range(0, 99);
            if (roll < insert_pct)
                cmd = CMD_INSERT;
            else if (roll < insert_pct + remove_pct)
                cmd = CMD_REMOVE;
            else if (roll < 95)
                cmd = CMD_MEMBER;
            else
                cmd = CMD_UNUSED;
            roll = $urandom_range(0, 99);
            if (roll < 50)
                key = key_pool[$urandom_range(0, 79)];
            else if (roll < 85 && held_count > 0)
                key = held_keys[$urandom_range(0, held_count - 1)];
            else
                key = $urandom();
            send_request(cmd, key);
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_req          <= '0;
        held_count     = 0;
        peak_count     = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        result_count   = 0;
        insert_count   = 0;
        remove_count   = 0;
        query_count    = 0;
        full_refusals  = 0;
        sender_idles   = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_ops();
        drain_results();
        test_fill_to_capacity();
        test_random_mix(450, 20, 55);   // shrink from full
        drain_results();
        test_random_mix(550, 60, 20);   // grow back toward capacity
        test_random_mix(550, 40, 35);   // balanced churn

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests: %0d inserts, %0d removes, %0d queries",
                 insert_count + remove_count + query_count, insert_count,
                 remove_count, query_count);
        $display("Table peaked at %0d keys, %0d inserts refused as full, %0d mismatches",
                 peak_count, full_refusals, mismatch_count);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
